/* rtl/ppdf_pkg.sv */
// Package with the types, constants and FCS function of the PPP async deframer.
package ppdf_pkg;

   localparam logic [7:0]  FLAG_BYTE = 8'h7E;
   localparam logic [7:0]  ESC_BYTE  = 8'h7D;
   localparam logic [7:0]  ESC_XOR   = 8'h20;
   localparam logic [7:0]  CTRL_LIMIT = 8'h20;
   localparam logic [15:0] FCS_INIT  = 16'hFFFF;
   localparam logic [15:0] FCS_GOOD  = 16'hF0B8;
   localparam logic [15:0] FCS_POLY  = 16'h8408;

   localparam int unsigned OUT_DEPTH = 4;

   typedef enum logic [1:0] {
      ST_GOOD  = 2'd0,
      ST_BAD   = 2'd1,
      ST_ABORT = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       last_in_datagram;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic [1:0] frame_status;
   } rsp_payload_type;

   function automatic logic [15:0] fcs_update(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] v;
      v = acc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (v[0]) begin
            v = (v >> 1) ^ FCS_POLY;
         end else begin
            v = v >> 1;
         end
      end
      return v;
   endfunction

endpackage

/* rtl/ppp_async_deframer_fcs_check.sv */
// PPP asynchronous HDLC-like deframer with FCS-16 check and a small result queue.
//
//   channel   direction  handshake           payload
//   req_      in         req_valid/req_stall req_data  (rx_byte, last_in_datagram)
//   rsp_      out        rsp_valid/rsp_stall rsp_data  (out_byte, frame_end, frame_status)
//   csr_      in/out     APB-style           rx_accm at byte address 0
//
// A byte is decoded in the cycle of its transaction and its results enter a
// four-entry queue, so one byte is taken every cycle while the queue has room
// for two results. A byte that gives two results needs two queue entries;
// req_stall rises when the queue has fewer than two free entries. Reset is
// synchronous; it clears the frame state, the queue and rx_accm.
module ppp_async_deframer_fcs_check (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ppdf_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ppdf_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [2:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   localparam int unsigned PTR_W = $clog2(ppdf_pkg::OUT_DEPTH);
   localparam int unsigned CNT_W = $clog2(ppdf_pkg::OUT_DEPTH + 1);

   logic [31:0]       rx_accm_ff;
   logic [15:0]       crc_ff, crc_in;
   logic              esc_ff, esc_in;
   logic              at_start_ff, at_start_in;
   logic              closed_ff, closed_in;
   logic [7:0]        held0_ff, held0_in, held1_ff, held1_in;
   logic [1:0]        held_cnt_ff, held_cnt_in;

   ppdf_pkg::rsp_payload_type queue_ff [ppdf_pkg::OUT_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              req_accept, rsp_accept, csr_write;
   ppdf_pkg::rsp_payload_type res0, res1;
   logic [1:0]        n_push;
   logic [7:0]        b, d;
   logic              is_ctrl_drop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? rx_accm_ff : 32'h0;

   assign req_stall  = (count_ff > CNT_W'(ppdf_pkg::OUT_DEPTH - 2));
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (count_ff != '0);
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign rsp_data   = queue_ff[rd_ptr_ff];

   assign b = req_data.rx_byte;
   assign d = esc_ff ? (b ^ ppdf_pkg::ESC_XOR) : b;
   assign is_ctrl_drop = (b < ppdf_pkg::CTRL_LIMIT) && rx_accm_ff[b[4:0]];

   always_comb begin
      crc_in      = crc_ff;
      esc_in      = esc_ff;
      at_start_in = at_start_ff;
      closed_in   = closed_ff;
      held0_in    = held0_ff;
      held1_in    = held1_ff;
      held_cnt_in = held_cnt_ff;
      res0        = '0;
      res1        = '0;
      n_push      = 2'd0;
      if (req_accept) begin
         if (closed_ff) begin
            closed_in = closed_ff;
         end else if (at_start_ff && b == ppdf_pkg::FLAG_BYTE) begin
            at_start_in = 1'b0;
         end else begin
            at_start_in = 1'b0;
            if (b == ppdf_pkg::FLAG_BYTE) begin
               res0.frame_end    = 1'b1;
               res0.frame_status = (crc_ff == ppdf_pkg::FCS_GOOD) ? ppdf_pkg::ST_GOOD
                                                                  : ppdf_pkg::ST_BAD;
               n_push      = 2'd1;
               closed_in   = 1'b1;
               held_cnt_in = 2'd0;
            end else if (b == ppdf_pkg::ESC_BYTE) begin
               esc_in = 1'b1;
            end else if (!is_ctrl_drop) begin
               esc_in = 1'b0;
               crc_in = ppdf_pkg::fcs_update(crc_ff, d);
               if (held_cnt_ff == 2'd2) begin
                  res0.out_byte = held0_ff;
                  n_push        = 2'd1;
                  held0_in      = held1_ff;
                  held1_in      = d;
               end else if (held_cnt_ff == 2'd1) begin
                  held1_in    = d;
                  held_cnt_in = 2'd2;
               end else begin
                  held0_in    = d;
                  held_cnt_in = 2'd1;
               end
            end
         end
         if (req_data.last_in_datagram) begin
            if (!closed_in) begin
               if (n_push == 2'd0) begin
                  res0.frame_end    = 1'b1;
                  res0.frame_status = ppdf_pkg::ST_ABORT;
               end else begin
                  res1.frame_end    = 1'b1;
                  res1.frame_status = ppdf_pkg::ST_ABORT;
               end
               n_push = n_push + 2'd1;
            end
            crc_in      = ppdf_pkg::FCS_INIT;
            esc_in      = 1'b0;
            at_start_in = 1'b1;
            closed_in   = 1'b0;
            held_cnt_in = 2'd0;
         end
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(n_push);
      rd_ptr_in = rsp_accept ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(n_push) - CNT_W'(rsp_accept);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_accm_ff  <= 32'h0;
         crc_ff      <= ppdf_pkg::FCS_INIT;
         esc_ff      <= 1'b0;
         at_start_ff <= 1'b1;
         closed_ff   <= 1'b0;
         held_cnt_ff <= 2'd0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         if (csr_write && csr_paddr[2] == 1'b0) begin
            rx_accm_ff <= csr_pwdata;
         end
         crc_ff      <= crc_in;
         esc_ff      <= esc_in;
         at_start_ff <= at_start_in;
         closed_ff   <= closed_in;
         held_cnt_ff <= held_cnt_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      held0_ff <= held0_in;
      held1_ff <= held1_in;
      if (n_push != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (n_push == 2'd2) begin
         queue_ff[wr_ptr_ff + PTR_W'(1)] <= res1;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ppdf_pkg::OUT_DEPTH))
      else $error("Result queue count exceeds its depth.");

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (count_ff <= CNT_W'(ppdf_pkg::OUT_DEPTH - 2)))
      else $error("Transaction accepted without room for two results.");

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_cnt_ff != 2'd3)
      else $error("Held byte count out of range.");

   a_datagram_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.last_in_datagram) |=>
         (at_start_ff && !closed_ff && !esc_ff && crc_ff == ppdf_pkg::FCS_INIT
          && held_cnt_ff == 2'd0))
      else $error("Frame state not cleared after the last byte of a datagram.");

   a_closed_no_output: assert property (@(posedge clock) disable iff (reset)
      (req_accept && closed_ff && !req_data.last_in_datagram) |-> (n_push == 2'd0))
      else $error("Result produced for a byte after the closing flag.");
`endif

endmodule
